@@ hw/rtl/sum_checked_frame_receiver_top_macros.svh @@
// ----------------------------------------------------------------------------
// Sum-checked frame receiver assertion macros
// Shared assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SUM_CHECKED_FRAME_RECEIVER_TOP_MACROS_SVH
`define SUM_CHECKED_FRAME_RECEIVER_TOP_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define SCFR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define SCFR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define SCFR_ASSERT_RST_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/scfr_pkg.sv @@
// ----------------------------------------------------------------------------
// Sum-checked frame receiver package
// Types, frame layout constants and helper functions shared by the block.
// ----------------------------------------------------------------------------
package scfr_pkg;

  // Frame layout: header at position 0, tail at the last position.
  localparam int unsigned FRAME_LEN = 11;
  localparam logic [3:0]  POS_LEN   = 4'd1;
  localparam logic [3:0]  PAY_FIRST = 4'd4;
  localparam int unsigned PAY_BYTES = 5;
  localparam logic [3:0]  POS_CHECK = 4'd9;
  localparam logic [3:0]  POS_LAST  = 4'(FRAME_LEN - 1);
  localparam logic [3:0]  SUM_MAX   = 4'd9;
  localparam logic [7:0]  FAIL_MAX  = 8'hFF;

  // Configuration register indexes.
  localparam logic [1:0] CFG_HEADER     = 2'd0;
  localparam logic [1:0] CFG_TAIL       = 2'd1;
  localparam logic [1:0] CFG_RETRY_LOW  = 2'd2;
  localparam logic [1:0] CFG_RETRY_HIGH = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [7:0] HEADER_RST     = 8'h5A;
  localparam logic [7:0] TAIL_RST       = 8'hA5;
  localparam logic [7:0] RETRY_LOW_RST  = 8'd10;
  localparam logic [7:0] RETRY_HIGH_RST = 8'd12;

  // Input action codes.
  localparam logic ACT_BYTE    = 1'b0;
  localparam logic ACT_TIMEOUT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CHECKSUM = 2'd1,
    ST_TAIL    = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] header_byte;
    logic [7:0] tail_byte;
    logic [7:0] retry_low;
    logic [7:0] retry_high;
  } cfg_t;

  // Frame result handed from the frame tracker to the link monitor.
  typedef struct packed {
    logic                       valid;
    status_t                    status;
    logic [8*PAY_BYTES-1:0]     payload;
  } frame_evt_t;

  // Number of leading bytes covered by the checksum: L-2 clamped to 0..9.
  function automatic logic [3:0] sum_count(input logic [7:0] len);
    logic [7:0] n;
    begin
      n = len - 8'd2;
      if (len < 8'd2) begin
        sum_count = 4'd0;
      end else if (n > 8'(SUM_MAX)) begin
        sum_count = SUM_MAX;
      end else begin
        sum_count = n[3:0];
      end
    end
  endfunction

endpackage

@@ hw/rtl/scfr_cfg.sv @@
// ----------------------------------------------------------------------------
// Sum-checked frame receiver configuration registers
// Holds header, tail and retry window values written through the write port.
// ----------------------------------------------------------------------------
module scfr_cfg (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr_en,
  input  logic [1:0]    cfg_index,
  input  logic [7:0]    cfg_data,
  output scfr_pkg::cfg_t cfg
);
  import scfr_pkg::*;

  // Register file with decoded writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_byte <= HEADER_RST;
      cfg.tail_byte   <= TAIL_RST;
      cfg.retry_low   <= RETRY_LOW_RST;
      cfg.retry_high  <= RETRY_HIGH_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_HEADER:     cfg.header_byte <= cfg_data;
        CFG_TAIL:       cfg.tail_byte   <= cfg_data;
        CFG_RETRY_LOW:  cfg.retry_low   <= cfg_data;
        CFG_RETRY_HIGH: cfg.retry_high  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/scfr_frame.sv @@
// ----------------------------------------------------------------------------
// Sum-checked frame receiver frame tracker
// Registers each input request, hunts for the header, collects the frame and
// raises a frame event on completion or timeout.
// ----------------------------------------------------------------------------
module scfr_frame (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 action,
  input  logic [7:0]           rx_byte,
  input  scfr_pkg::cfg_t       cfg,
  input  logic                 can_load,
  output scfr_pkg::frame_evt_t evt
);
  import scfr_pkg::*;

  logic       q_valid;
  logic       q_action;
  logic [7:0] q_byte;
  logic       proceed;

  logic                     in_frame, in_frame_next;
  logic [3:0]               byte_pos, byte_pos_next;
  logic [3:0]               sum_cnt, sum_cnt_next;
  logic [7:0]               running_sum, running_sum_next;
  logic [7:0]               check_byte, check_byte_next;
  logic [8*PAY_BYTES-1:0]   payload_store, payload_store_next;

  // The stored request moves on whenever the result register can take it.
  assign proceed  = q_valid && can_load;
  assign in_ready = !q_valid || proceed;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      q_valid <= 1'b1;
    end else if (proceed) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_action <= action;
      q_byte   <= rx_byte;
    end
  end

  // Frame state update for one stored request.
  always_comb begin
    logic [3:0] n;
    in_frame_next      = in_frame;
    byte_pos_next      = byte_pos;
    sum_cnt_next       = sum_cnt;
    running_sum_next   = running_sum;
    check_byte_next    = check_byte;
    payload_store_next = payload_store;
    evt.valid          = 1'b0;
    evt.status         = ST_OK;
    evt.payload        = payload_store;
    n                  = sum_count(q_byte);

    if (q_action == ACT_TIMEOUT) begin
      // Timeout drops any partial frame.
      evt.valid     = q_valid;
      evt.status    = ST_TIMEOUT;
      evt.payload   = '0;
      in_frame_next = 1'b0;
      byte_pos_next = '0;
    end else if (!in_frame) begin
      if (q_byte == cfg.header_byte) begin
        in_frame_next    = 1'b1;
        byte_pos_next    = POS_LEN;
        running_sum_next = '0;
        check_byte_next  = '0;
      end
    end else begin
      if (byte_pos == POS_LEN) begin
        // Length byte: seed the sum with header and length as covered.
        sum_cnt_next     = n;
        running_sum_next = ((n >= 4'd1) ? cfg.header_byte : 8'd0)
                         + ((n >= 4'd2) ? q_byte : 8'd0);
      end else if (byte_pos < POS_CHECK) begin
        if (byte_pos < sum_cnt) begin
          running_sum_next = running_sum + q_byte;
        end
        for (int i = 0; i < PAY_BYTES; i++) begin
          if (byte_pos == PAY_FIRST + 4'(i)) begin
            payload_store_next[8*i +: 8] = q_byte;
          end
        end
      end else if (byte_pos == POS_CHECK) begin
        check_byte_next = q_byte;
      end

      if (byte_pos >= POS_LAST) begin
        // Last byte: checksum first, then the tail.
        evt.valid = q_valid;
        if (running_sum != check_byte) begin
          evt.status = ST_CHECKSUM;
        end else if (q_byte != cfg.tail_byte) begin
          evt.status = ST_TAIL;
        end else begin
          evt.status = ST_OK;
        end
        in_frame_next = 1'b0;
        byte_pos_next = '0;
      end else begin
        byte_pos_next = byte_pos + 4'd1;
      end
    end
  end

  // Frame state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      byte_pos    <= '0;
      sum_cnt     <= '0;
      running_sum <= '0;
      check_byte  <= '0;
    end else if (proceed) begin
      in_frame    <= in_frame_next;
      byte_pos    <= byte_pos_next;
      sum_cnt     <= sum_cnt_next;
      running_sum <= running_sum_next;
      check_byte  <= check_byte_next;
    end
  end

  always_ff @(posedge clk) begin
    if (proceed) begin
      payload_store <= payload_store_next;
    end
  end

endmodule

@@ hw/rtl/scfr_link.sv @@
// ----------------------------------------------------------------------------
// Sum-checked frame receiver link monitor
// Keeps the saturating failure count, derives the link flags and holds the
// result register toward the output channel.
// ----------------------------------------------------------------------------
module scfr_link (
  input  logic                   clk,
  input  logic                   rst,
  input  scfr_pkg::cfg_t         cfg,
  input  scfr_pkg::frame_evt_t   evt,
  output logic                   can_load,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             status,
  output logic [39:0]            payload,
  output logic                   first_failure,
  output logic                   mark_bad,
  output logic                   recovered
);
  import scfr_pkg::*;

  logic [7:0] fail_count, fail_count_next;
  logic       load;
  logic       ok;
  logic       first_next, bad_next, rec_next;

  assign can_load = !out_valid || out_ready;
  assign load     = evt.valid && can_load;
  assign ok       = (evt.status == ST_OK);

  // Flags and next failure count for the incoming result.
  always_comb begin
    first_next      = 1'b0;
    bad_next        = 1'b0;
    rec_next        = 1'b0;
    fail_count_next = fail_count;
    if (ok) begin
      rec_next        = (fail_count != 8'd0);
      fail_count_next = '0;
    end else begin
      first_next = (fail_count == 8'd0);
      bad_next   = (fail_count >= cfg.retry_low) && (fail_count <= cfg.retry_high);
      if (fail_count != FAIL_MAX) begin
        fail_count_next = fail_count + 8'd1;
      end
    end
  end

  // Failure counter and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      fail_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (load) begin
        fail_count <= fail_count_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (load) begin
      status        <= evt.status;
      payload       <= evt.payload;
      first_failure <= first_next;
      mark_bad      <= bad_next;
      recovered     <= rec_next;
    end
  end

endmodule

@@ hw/rtl/sum_checked_frame_receiver_top.sv @@
// ----------------------------------------------------------------------------
// Sum-checked frame receiver
// Finds header-started 11-byte reply frames, checks sum and tail, and reports
// each frame or timeout with link health flags.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one request per cycle:
//   action 0 with a received byte in rx_byte, or action 1 for a read timeout.
//   The output channel (out_valid/out_ready) carries one result per finished
//   frame or timeout: status, payload bytes 4..8 and the three link flags.
//   Bytes outside a frame produce no result until the header value arrives.
//   A request is first held in the input register and its result is then
//   loaded into the output register, which raises out_valid. One request
//   is taken every cycle while the output register is free or being
//   drained; the result register sets this rate.
//   When out_ready is low with a result waiting, the stored request holds and
//   in_ready drops once the input register is full; nothing is lost.
//   Reset clears the frame tracker, the failure count and both valid flags,
//   and loads header 0x5A, tail 0xA5 and the retry window 10..12.
//   Configuration writes take effect at the edge where cfg_wr_en is high.
// ----------------------------------------------------------------------------
module sum_checked_frame_receiver_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [39:0] payload,
  output logic        first_failure,
  output logic        mark_bad,
  output logic        recovered
);
  import scfr_pkg::*;

  cfg_t       cfg;
  frame_evt_t evt;
  logic       can_load;

  // Configuration registers.
  scfr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register and frame tracking.
  scfr_frame u_frame (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .rx_byte  (rx_byte),
    .cfg      (cfg),
    .can_load (can_load),
    .evt      (evt)
  );

  // Failure counting and result register.
  scfr_link u_link (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .evt           (evt),
    .can_load      (can_load),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .payload       (payload),
    .first_failure (first_failure),
    .mark_bad      (mark_bad),
    .recovered     (recovered)
  );

endmodule

@@ hw/rtl/scfr_checker.sv @@
// ----------------------------------------------------------------------------
// Sum-checked frame receiver port checker
// Watches the top-level ports for result consistency and stall behavior.
// ----------------------------------------------------------------------------
`include "sum_checked_frame_receiver_top_macros.svh"

module scfr_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [39:0] payload,
  input logic        first_failure,
  input logic        mark_bad,
  input logic        recovered
);
  import scfr_pkg::*;

  // A stalled result keeps its valid and its payload.
  `SCFR_ASSERT_NXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(payload) && $stable(status), "stalled result changed")

  // Failure flags only come with a failing status.
  `SCFR_ASSERT_IMP(a_fail_flags, out_valid && (first_failure || mark_bad), status != ST_OK, "failure flag on a good frame")

  // Recovery only comes with a good frame and no failure flags.
  `SCFR_ASSERT_IMP(a_recover, out_valid && recovered, status == ST_OK && !first_failure && !mark_bad, "recovered flag on a failed result")

  // Timeout results carry an empty payload.
  `SCFR_ASSERT_IMP(a_timeout_pay, out_valid && status == ST_TIMEOUT, payload == '0, "timeout result with payload")

  // Reset empties the result register.
  `SCFR_ASSERT_RST_NXT(a_reset, rst, !out_valid, "result valid after reset")

endmodule

bind sum_checked_frame_receiver_top scfr_checker u_scfr_checker (.*);

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sum-checked frame receiver testbench
// Drives received bytes and timeouts through the request channel while
// tracking the frame hunt, checksum, tail and failure counter in a local
// model. Every result is checked field by field against that model, under
// random idling on both channels and several register settings.
// ----------------------------------------------------------------------------
module tb;
  import scfr_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 8;

  // One request on the input channel.
  typedef struct {
    logic       act;
    logic [7:0] data;
  } rx_event_t;

  // One expected frame or timeout report.
  typedef struct {
    status_t     status;
    logic [39:0] payload;
    logic        first_failure;
    logic        mark_bad;
    logic        recovered;
  } frame_report_t;

  typedef enum {FR_GOOD, FR_BAD_SUM, FR_BAD_TAIL, FR_CUT} frame_kind_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = CFG_HEADER;
  logic [7:0]  cfg_data = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        action = ACT_BYTE;
  logic [7:0]  rx_byte = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [1:0]  status;
  logic [39:0] payload;
  logic        first_failure;
  logic        mark_bad;
  logic        recovered;

  sum_checked_frame_receiver_top u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .payload       (payload),
    .first_failure (first_failure),
    .mark_bad      (mark_bad),
    .recovered     (recovered)
  );

  // Local copy of the registers and of the frame tracker state.
  logic [7:0]  hdr_cfg = HEADER_RST;
  logic [7:0]  tail_cfg = TAIL_RST;
  logic [7:0]  win_lo_cfg = RETRY_LOW_RST;
  logic [7:0]  win_hi_cfg = RETRY_HIGH_RST;
  logic        trk_in_frame = 1'b0;
  logic [3:0]  trk_pos = 4'd0;
  logic [7:0]  trk_len = 8'd0;
  logic [7:0]  trk_sum = 8'd0;
  logic [7:0]  trk_check = 8'd0;
  logic [39:0] trk_payload = 40'd0;
  logic [7:0]  fail_cnt = 8'd0;

  rx_event_t     pending_rx[$];
  frame_report_t expected_reports[$];
  rx_event_t     send_item;
  int            queued_cnt = 0;
  int            err_count = 0;
  int            cycle_cnt = 0;
  int            send_gap = 0;
  int            stall_left = 0;
  bit            calm = 1'b0;
  bit            in_fire = 1'b0;

  // Clock generation.
  initial begin
    forever #2 clk = ~clk;
  end

  // Number of leading frame bytes covered by the checksum.
  function automatic int covered_len(input logic [7:0] len);
    if (len < 8'd2) begin
      return 0;
    end
    return (len - 8'd2 > 8'd9) ? 9 : int'(len - 8'd2);
  endfunction

  function automatic void drop_frame();
    trk_in_frame = 1'b0;
    trk_pos = 4'd0;
    trk_len = 8'd0;
    trk_sum = 8'd0;
    trk_check = 8'd0;
    trk_payload = 40'd0;
  endfunction

  // Builds a report and updates the failure counter and link flags.
  function automatic frame_report_t link_report(input status_t st, input logic [39:0] pl);
    frame_report_t r;
    r.status = st;
    r.payload = pl;
    r.first_failure = 1'b0;
    r.mark_bad = 1'b0;
    r.recovered = 1'b0;
    if (st == ST_OK) begin
      r.recovered = (fail_cnt != 8'd0);
      fail_cnt = 8'd0;
    end else begin
      r.first_failure = (fail_cnt == 8'd0);
      r.mark_bad = (fail_cnt >= win_lo_cfg) && (fail_cnt <= win_hi_cfg);
      if (fail_cnt != FAIL_MAX) begin
        fail_cnt = fail_cnt + 8'd1;
      end
    end
    return r;
  endfunction

  // Advances the frame tracker by one request; got is set when a report follows.
  function automatic void track_request(input logic act, input logic [7:0] b,
                                        output bit got, output frame_report_t r);
    logic [3:0]  pos;
    logic [39:0] pl;
    status_t     st;
    got = 1'b0;
    r = '{ST_OK, 40'd0, 1'b0, 1'b0, 1'b0};
    if (act == ACT_TIMEOUT) begin
      drop_frame();
      r = link_report(ST_TIMEOUT, 40'd0);
      got = 1'b1;
    end else if (!trk_in_frame) begin
      if (b == hdr_cfg) begin
        drop_frame();
        trk_in_frame = 1'b1;
        trk_pos = POS_LEN;
      end
    end else begin
      pos = trk_pos;
      if (pos == POS_LEN) begin
        trk_len = b;
        trk_sum = 8'd0;
        if (covered_len(b) >= 1) trk_sum = trk_sum + hdr_cfg;
        if (covered_len(b) >= 2) trk_sum = trk_sum + b;
      end else if (pos < POS_CHECK) begin
        if (pos < covered_len(trk_len)) trk_sum = trk_sum + b;
        if (pos >= PAY_FIRST) trk_payload[8*(pos-PAY_FIRST) +: 8] = b;
      end else if (pos == POS_CHECK) begin
        trk_check = b;
      end
      if (pos >= POS_LAST) begin
        pl = trk_payload;
        if (trk_sum != trk_check) st = ST_CHECKSUM;
        else if (b != tail_cfg) st = ST_TAIL;
        else st = ST_OK;
        drop_frame();
        r = link_report(st, pl);
        got = 1'b1;
      end else begin
        trk_pos = pos + 4'd1;
      end
    end
  endfunction

  function automatic void check_field(input string name, input logic [39:0] want,
                                      input logic [39:0] seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, seen);
      err_count++;
    end
  endfunction

  // Monitor: checks each accepted result, then predicts the accepted request.
  always @(posedge clk) begin
    bit            got;
    frame_report_t r;
    in_fire <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d payload %h",
                   $time, status, payload);
          err_count++;
        end else begin
          r = expected_reports.pop_front();
          check_field("status", 40'(r.status), 40'(status));
          check_field("payload", r.payload, payload);
          check_field("first_failure", 40'(r.first_failure), 40'(first_failure));
          check_field("mark_bad", 40'(r.mark_bad), 40'(mark_bad));
          check_field("recovered", 40'(r.recovered), 40'(recovered));
        end
      end
      if (in_valid && in_ready) begin
        track_request(action, rx_byte, got, r);
        if (got) expected_reports.push_back(r);
      end
    end
  end

  // Request driver: holds a request until taken, idles in random bursts.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      // The current request is still waiting to be taken.
    end else if (send_gap != 0) begin
      in_valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_rx.size() != 0 && !calm && $urandom_range(0, 15) == 0) begin
      in_valid <= 1'b0;
      send_gap <= $urandom_range(0, 13);
    end else if (pending_rx.size() != 0) begin
      send_item = pending_rx.pop_front();
      in_valid <= 1'b1;
      action <= send_item.act;
      rx_byte <= send_item.data;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result stalls in random bursts.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 15) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 13);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_reports.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    pending_rx.push_back('{ACT_BYTE, b});
    queued_cnt++;
  endtask

  task automatic push_timeout();
    pending_rx.push_back('{ACT_TIMEOUT, 8'($urandom_range(0, 255))});
    queued_cnt++;
  endtask

  // Queues one frame with random content; a cut frame ends in a timeout.
  task automatic queue_frame(input frame_kind_t kind, input logic [7:0] len);
    logic [7:0] fb [0:10];
    logic [7:0] sum;
    int         cut;
    int         i;
    fb[0] = hdr_cfg;
    fb[1] = len;
    for (i = 2; i <= 8; i++) fb[i] = 8'($urandom_range(0, 255));
    sum = 8'd0;
    for (i = 0; i < covered_len(len); i++) sum = sum + fb[i];
    fb[9] = (kind == FR_BAD_SUM) ? (sum ^ 8'($urandom_range(1, 255))) : sum;
    fb[10] = (kind == FR_BAD_TAIL) ? (tail_cfg ^ 8'($urandom_range(1, 255))) : tail_cfg;
    cut = (kind == FR_CUT) ? $urandom_range(1, 10) : 11;
    for (i = 0; i < cut; i++) push_byte(fb[i]);
    if (kind == FR_CUT) push_timeout();
  endtask

  // Mostly well-formed frames, with noise, stray headers and timeouts mixed in.
  task automatic fill_random(input int target);
    int         goal;
    int         pick;
    logic [7:0] len;
    logic [7:0] b;
    goal = queued_cnt + target;
    while (queued_cnt < goal) begin
      pick = $urandom_range(0, 99);
      len = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(0, 12));
      if (pick < 55) begin
        queue_frame(FR_GOOD, len);
      end else if (pick < 67) begin
        queue_frame(FR_BAD_SUM, len);
      end else if (pick < 77) begin
        queue_frame(FR_BAD_TAIL, len);
      end else if (pick < 85) begin
        queue_frame(FR_CUT, len);
      end else if (pick < 93) begin
        b = 8'($urandom_range(0, 255));
        if (b == hdr_cfg) b = ~b;
        push_byte(b);
      end else if (pick < 95) begin
        push_byte(hdr_cfg);
      end else begin
        push_timeout();
      end
    end
  endtask

  // Waits until every request is taken and every result has come, then
  // lets the pipeline settle.
  task automatic wait_quiet();
    while (pending_rx.size() != 0 || in_valid || expected_reports.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_HEADER:     hdr_cfg = val;
      CFG_TAIL:       tail_cfg = val;
      CFG_RETRY_LOW:  win_lo_cfg = val;
      CFG_RETRY_HIGH: win_hi_cfg = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Stimulus sequence.
  initial begin
    logic [7:0] short_frame [0:10];
    int         i;
    short_frame = '{8'h5A, 8'h01, 8'h5A, 8'hFF, 8'h00, 8'hFF, 8'h5A, 8'h80, 8'h01,
                    8'h00, 8'hA5};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: timeout while hunting, junk bytes, a short-length frame
    // carrying the header value as data, and a clamped-length frame with a bad tail.
    push_timeout();
    push_byte(8'h00);
    push_byte(8'hFF);
    for (i = 0; i < 11; i++) push_byte(short_frame[i]);
    queue_frame(FR_BAD_TAIL, 8'hFF);
    fill_random(200);
    wait_quiet();
    fill_random(220);
    wait_quiet();

    // Zero header, all-ones tail, retry window of a single count at zero.
    write_reg(CFG_HEADER, 8'h00);
    write_reg(CFG_TAIL, 8'hFF);
    write_reg(CFG_RETRY_LOW, 8'd0);
    write_reg(CFG_RETRY_HIGH, 8'd0);
    fill_random(320);
    wait_quiet();

    // All-ones header, zero tail, window at the top; a long run of timeouts
    // drives the failure counter into saturation before frames resume.
    write_reg(CFG_HEADER, 8'hFF);
    write_reg(CFG_TAIL, 8'h00);
    write_reg(CFG_RETRY_LOW, 8'd250);
    write_reg(CFG_RETRY_HIGH, 8'd255);
    for (i = 0; i < 262; i++) push_timeout();
    fill_random(160);
    wait_quiet();

    // Random header and tail with a narrow low window; no idling from here on.
    write_reg(CFG_HEADER, 8'($urandom_range(0, 255)));
    write_reg(CFG_TAIL, 8'($urandom_range(0, 255)));
    write_reg(CFG_RETRY_LOW, 8'd1);
    write_reg(CFG_RETRY_HIGH, 8'd3);
    calm = 1'b1;
    fill_random(260);
    wait_quiet();

    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
